// ===== hdl/scf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package scf_pkg;
    // Default fraction width of the Q formats
    localparam int FRAC_BITS_DEF = 16;

    // Field widths
    localparam int POS_W   = 32;
    localparam int DIFF_W  = 33;
    localparam int SQR_W   = 66;
    localparam int ROOT_W  = 33;
    localparam int REM_W   = 36;
    localparam int LEN_W   = 31;
    localparam int STIFF_W = 18;
    localparam int PROD_W  = 52;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] REG_REST_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IS_BROKEN   = 3'd3;

    localparam logic [LEN_W-1:0]   RST_REST_LENGTH = 31'd65536;
    localparam logic [LEN_W-1:0]   RST_MAX_LENGTH  = 31'd65536;
    localparam logic [STIFF_W-1:0] RST_STIFFNESS   = 18'd65536;
endpackage
`default_nettype wire

// ===== hdl/spring_constraint_force.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_stall  i_a_x, i_a_y, i_b_x, i_b_y
// result    out        o_valid / i_stall  o_force_x, o_force_y, o_active
// config    in         i_cfg_we           i_cfg_idx, i_cfg_data
//
// One item per cycle unless a held result stalls; stages 0-2, square root (one
// root bit per stage), D, S, divider (one quotient bit per stage), M, output.
// Reset clears all valid bits and loads the register defaults.
// A waiting result freezes the whole pipeline; o_stall is high only then.
module spring_constraint_force
    import scf_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_valid,
    output logic                        o_stall,
    input  wire  signed [POS_W-1:0]     i_a_x,
    input  wire  signed [POS_W-1:0]     i_a_y,
    input  wire  signed [POS_W-1:0]     i_b_x,
    input  wire  signed [POS_W-1:0]     i_b_y,
    output logic                        o_valid,
    input  wire                         i_stall,
    output logic signed [POS_W-1:0]     o_force_x,
    output logic signed [POS_W-1:0]     o_force_y,
    output logic                        o_active,
    input  wire                         i_cfg_we,
    input  wire         [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire         [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int SQ_N = ROOT_W;
    localparam int DV_N = FRAC_BITS + 1;
    localparam int NW   = DIFF_W + FRAC_BITS + 1;
    localparam int QW   = FRAC_BITS + 1;
    localparam int UW   = FRAC_BITS + 2;
    localparam int SW   = PROD_W - FRAC_BITS;
    localparam int PXW  = SW + UW;

    // Configuration registers
    logic [LEN_W-1:0]   r_rest_length;
    logic [LEN_W-1:0]   r_max_length;
    logic [STIFF_W-1:0] r_stiffness;
    logic               r_is_broken;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rest_length <= RST_REST_LENGTH;
            r_max_length  <= RST_MAX_LENGTH;
            r_stiffness   <= RST_STIFFNESS;
            r_is_broken   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_REST_LENGTH: r_rest_length <= i_cfg_data[LEN_W-1:0];
                REG_MAX_LENGTH:  r_max_length  <= i_cfg_data[LEN_W-1:0];
                REG_STIFFNESS:   r_stiffness   <= i_cfg_data[STIFF_W-1:0];
                REG_IS_BROKEN:   r_is_broken   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Global advance: the pipeline moves unless a result is held
    logic en;
    logic r_out_v;
    assign en      = !(r_out_v && i_stall);
    assign o_stall = r_out_v && i_stall;
    assign o_valid = r_out_v;

    // Stage 0: offsets and magnitudes
    logic                     r_v0;
    logic signed [DIFF_W-1:0] r_dx0, r_dy0;
    logic        [DIFF_W-1:0] r_mx0, r_my0;
    logic signed [DIFF_W-1:0] n_dx0, n_dy0;

    assign n_dx0 = DIFF_W'(i_a_x) - DIFF_W'(i_b_x);
    assign n_dy0 = DIFF_W'(i_a_y) - DIFF_W'(i_b_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v0 <= 1'b0;
        else if (en)  r_v0 <= i_valid;
        if (en) begin
            r_dx0 <= n_dx0;
            r_dy0 <= n_dy0;
            r_mx0 <= n_dx0[DIFF_W-1] ? DIFF_W'(-n_dx0) : DIFF_W'(n_dx0);
            r_my0 <= n_dy0[DIFF_W-1] ? DIFF_W'(-n_dy0) : DIFF_W'(n_dy0);
        end
    end

    // Stage 1: squares
    logic                     r_v1;
    logic signed [DIFF_W-1:0] r_dx1, r_dy1;
    logic        [SQR_W-1:0]  r_sx1, r_sy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else if (en)  r_v1 <= r_v0;
        if (en) begin
            r_dx1 <= r_dx0;
            r_dy1 <= r_dy0;
            r_sx1 <= SQR_W'(r_mx0) * SQR_W'(r_mx0);
            r_sy1 <= SQR_W'(r_my0) * SQR_W'(r_my0);
        end
    end

    // Stage 2: squared length (fits 66 bits)
    logic                     r_v2;
    logic signed [DIFF_W-1:0] r_dx2, r_dy2;
    logic        [SQR_W-1:0]  r_rad2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else if (en)  r_v2 <= r_v1;
        if (en) begin
            r_dx2  <= r_dx1;
            r_dy2  <= r_dy1;
            r_rad2 <= r_sx1 + r_sy1;
        end
    end

    // Square root: one root bit per stage
    logic                     r_sq_v    [SQ_N];
    logic signed [DIFF_W-1:0] r_sq_dx   [SQ_N];
    logic signed [DIFF_W-1:0] r_sq_dy   [SQ_N];
    logic        [SQR_W-1:0]  r_sq_rad  [SQ_N];
    logic        [REM_W-1:0]  r_sq_rem  [SQ_N];
    logic        [ROOT_W-1:0] r_sq_root [SQ_N];

    genvar gs;
    generate
        for (gs = 0; gs < SQ_N; gs++) begin : g_sq
            logic                     p_v;
            logic signed [DIFF_W-1:0] p_dx, p_dy;
            logic        [SQR_W-1:0]  p_rad;
            logic        [REM_W-1:0]  p_rem;
            logic        [ROOT_W-1:0] p_root;
            logic        [REM_W-1:0]  n_rem, n_trial;

            if (gs == 0) begin : g_first
                assign p_v    = r_v2;
                assign p_dx   = r_dx2;
                assign p_dy   = r_dy2;
                assign p_rad  = r_rad2;
                assign p_rem  = '0;
                assign p_root = '0;
            end else begin : g_next
                assign p_v    = r_sq_v[gs-1];
                assign p_dx   = r_sq_dx[gs-1];
                assign p_dy   = r_sq_dy[gs-1];
                assign p_rad  = r_sq_rad[gs-1];
                assign p_rem  = r_sq_rem[gs-1];
                assign p_root = r_sq_root[gs-1];
            end

            assign n_rem   = {p_rem[REM_W-3:0], p_rad[SQR_W-1 -: 2]};
            assign n_trial = {1'b0, p_root, 2'b01};

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) r_sq_v[gs] <= 1'b0;
                else if (en)  r_sq_v[gs] <= p_v;
                if (en) begin
                    r_sq_dx[gs]  <= p_dx;
                    r_sq_dy[gs]  <= p_dy;
                    r_sq_rad[gs] <= {p_rad[SQR_W-3:0], 2'b00};
                    if (n_rem >= n_trial) begin
                        r_sq_rem[gs]  <= n_rem - n_trial;
                        r_sq_root[gs] <= {p_root[ROOT_W-2:0], 1'b1};
                    end else begin
                        r_sq_rem[gs]  <= n_rem;
                        r_sq_root[gs] <= {p_root[ROOT_W-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    // Stage D: clamp, spring term product
    logic                     r_vd;
    logic signed [DIFF_W-1:0] r_dxd, r_dyd;
    logic        [ROOT_W-1:0] r_dd;
    logic signed [PROD_W-1:0] r_prodd;
    logic        [ROOT_W-1:0] d_in;
    logic        [LEN_W-1:0]  n_dc;
    logic signed [DIFF_W-1:0] n_diff;

    assign d_in   = r_sq_root[SQ_N-1];
    assign n_dc   = (d_in > ROOT_W'(r_max_length)) ? r_max_length : d_in[LEN_W-1:0];
    assign n_diff = DIFF_W'(r_rest_length) - DIFF_W'(n_dc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vd <= 1'b0;
        else if (en)  r_vd <= r_sq_v[SQ_N-1];
        if (en) begin
            r_dxd   <= r_sq_dx[SQ_N-1];
            r_dyd   <= r_sq_dy[SQ_N-1];
            r_dd    <= d_in;
            r_prodd <= PROD_W'(signed'({1'b0, r_stiffness})) * PROD_W'(n_diff);
        end
    end

    // Stage S: truncate spring term, set up dividends
    logic                     r_vs;
    logic signed [SW-1:0]     r_ss;
    logic        [ROOT_W-1:0] r_ds;
    logic                     r_sgx_s, r_sgy_s;
    logic        [NW-1:0]     r_nx_s, r_ny_s;
    logic signed [PROD_W-1:0] n_prod_adj;
    logic        [DIFF_W-1:0] n_mxd, n_myd;

    assign n_prod_adj = r_prodd + (r_prodd[PROD_W-1] ?
                        PROD_W'((64'd1 << FRAC_BITS) - 64'd1) : PROD_W'(0));
    assign n_mxd = r_dxd[DIFF_W-1] ? DIFF_W'(-r_dxd) : DIFF_W'(r_dxd);
    assign n_myd = r_dyd[DIFF_W-1] ? DIFF_W'(-r_dyd) : DIFF_W'(r_dyd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vs <= 1'b0;
        else if (en)  r_vs <= r_vd;
        if (en) begin
            r_ss    <= SW'(n_prod_adj >>> FRAC_BITS);
            r_ds    <= r_dd;
            r_sgx_s <= r_dxd[DIFF_W-1];
            r_sgy_s <= r_dyd[DIFF_W-1];
            r_nx_s  <= NW'(n_mxd) << FRAC_BITS;
            r_ny_s  <= NW'(n_myd) << FRAC_BITS;
        end
    end

    // Divider: one quotient bit per stage, both components in parallel
    logic                     r_dv_v   [DV_N];
    logic signed [SW-1:0]     r_dv_s   [DV_N];
    logic        [ROOT_W-1:0] r_dv_d   [DV_N];
    logic                     r_dv_sgx [DV_N];
    logic                     r_dv_sgy [DV_N];
    logic        [NW-1:0]     r_dv_rx  [DV_N];
    logic        [NW-1:0]     r_dv_ry  [DV_N];
    logic        [QW-1:0]     r_dv_qx  [DV_N];
    logic        [QW-1:0]     r_dv_qy  [DV_N];

    genvar gd;
    generate
        for (gd = 0; gd < DV_N; gd++) begin : g_dv
            logic                     p_v, p_sgx, p_sgy;
            logic signed [SW-1:0]     p_s;
            logic        [ROOT_W-1:0] p_d;
            logic        [NW-1:0]     p_rx, p_ry, n_sub;
            logic        [QW-1:0]     p_qx, p_qy;
            logic                     n_gex, n_gey;
            logic        [NW-1:0]     n_rx, n_ry;
            logic        [QW-1:0]     n_qbit, n_qx, n_qy;

            if (gd == 0) begin : g_first
                assign p_v   = r_vs;
                assign p_s   = r_ss;
                assign p_d   = r_ds;
                assign p_sgx = r_sgx_s;
                assign p_sgy = r_sgy_s;
                assign p_rx  = r_nx_s;
                assign p_ry  = r_ny_s;
                assign p_qx  = '0;
                assign p_qy  = '0;
            end else begin : g_next
                assign p_v   = r_dv_v[gd-1];
                assign p_s   = r_dv_s[gd-1];
                assign p_d   = r_dv_d[gd-1];
                assign p_sgx = r_dv_sgx[gd-1];
                assign p_sgy = r_dv_sgy[gd-1];
                assign p_rx  = r_dv_rx[gd-1];
                assign p_ry  = r_dv_ry[gd-1];
                assign p_qx  = r_dv_qx[gd-1];
                assign p_qy  = r_dv_qy[gd-1];
            end

            // divisor aligned to quotient bit FRAC_BITS-gd
            assign n_sub  = NW'(p_d) << (FRAC_BITS - gd);
            assign n_qbit = QW'(1) << (FRAC_BITS - gd);

            // subtract where it fits; a zero length leaves the quotient at zero
            assign n_gex = (p_d != '0) && (p_rx >= n_sub);
            assign n_gey = (p_d != '0) && (p_ry >= n_sub);
            assign n_rx  = n_gex ? p_rx - n_sub : p_rx;
            assign n_ry  = n_gey ? p_ry - n_sub : p_ry;
            assign n_qx  = n_gex ? (p_qx | n_qbit) : p_qx;
            assign n_qy  = n_gey ? (p_qy | n_qbit) : p_qy;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) r_dv_v[gd] <= 1'b0;
                else if (en)  r_dv_v[gd] <= p_v;
                if (en) begin
                    r_dv_s[gd]   <= p_s;
                    r_dv_d[gd]   <= p_d;
                    r_dv_sgx[gd] <= p_sgx;
                    r_dv_sgy[gd] <= p_sgy;
                    r_dv_qx[gd]  <= n_qx;
                    r_dv_qy[gd]  <= n_qy;
                    r_dv_rx[gd]  <= n_rx;
                    r_dv_ry[gd]  <= n_ry;
                end
            end
        end
    endgenerate

    // Stage M: signed direction times spring term
    logic                  r_vm;
    logic signed [PXW-1:0] r_pxm, r_pym;
    logic signed [UW-1:0]  n_ux, n_uy;
    logic        [QW-1:0]  q_x, q_y;

    assign q_x  = r_dv_qx[DV_N-1];
    assign q_y  = r_dv_qy[DV_N-1];
    assign n_ux = r_dv_sgx[DV_N-1] ? UW'(-signed'({1'b0, q_x})) : UW'(signed'({1'b0, q_x}));
    assign n_uy = r_dv_sgy[DV_N-1] ? UW'(-signed'({1'b0, q_y})) : UW'(signed'({1'b0, q_y}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vm <= 1'b0;
        else if (en)  r_vm <= r_dv_v[DV_N-1];
        if (en) begin
            r_pxm <= PXW'(r_dv_s[DV_N-1]) * PXW'(n_ux);
            r_pym <= PXW'(r_dv_s[DV_N-1]) * PXW'(n_uy);
        end
    end

    // Output stage: truncate toward zero, saturate, apply broken flag
    logic signed [PXW-1:0] n_fx, n_fy;
    logic signed [PXW-1:0] n_pxa, n_pya;

    assign n_pxa = r_pxm + (r_pxm[PXW-1] ?
                   PXW'((64'd1 << FRAC_BITS) - 64'd1) : PXW'(0));
    assign n_pya = r_pym + (r_pym[PXW-1] ?
                   PXW'((64'd1 << FRAC_BITS) - 64'd1) : PXW'(0));
    assign n_fx  = n_pxa >>> FRAC_BITS;
    assign n_fy  = n_pya >>> FRAC_BITS;

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [PXW-1:0] v);
        logic signed [PXW-1:0] hi_lim;
        logic signed [PXW-1:0] lo_lim;
        hi_lim = PXW'(64'sd2147483647);
        lo_lim = PXW'(-64'sd2147483648);
        if (v > hi_lim)      sat_pos = 32'sh7FFFFFFF;
        else if (v < lo_lim) sat_pos = 32'sh80000000;
        else                 sat_pos = v[POS_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_v <= 1'b0;
        else if (en)  r_out_v <= r_vm;
        if (en) begin
            o_force_x <= r_is_broken ? '0 : sat_pos(n_fx);
            o_force_y <= r_is_broken ? '0 : sat_pos(n_fy);
            o_active  <= !r_is_broken;
        end
    end

`ifndef SYNTHESIS
    // A frozen pipeline keeps its entry valid bit
    a_hold_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> r_v0 == $past(r_v0))
        else $error("entry stage changed while frozen");

    // Broken constraint gives zero force
    a_broken_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_active) |-> (o_force_x == '0 && o_force_y == '0))
        else $error("nonzero force on a broken constraint");

    // A stalled result advances nothing at the last stage
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_force_x) && $stable(o_force_y)))
        else $error("held result changed");
`endif
endmodule
`default_nettype wire
